// ===== design/urw_pkg.sv =====
// Shared types, constants and helpers for the UM receive reordering window.
`default_nettype none

package urw_pkg;

  localparam int SN_BITS  = 5;
  localparam int WINDOW   = 16;
  localparam int SN_MOD   = 1 << SN_BITS;
  localparam int CNT_BITS = SN_BITS + 1;
  localparam int SEQ_W    = 5;

  typedef logic [SN_BITS-1:0]  sn_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_PDU    = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_REEST  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_HDR_ERR = 2'd2,
    STAT_CTRL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PDU_EVAL,
    S_RUN_CHECK,
    S_RUN_EVAL,
    S_FIND,
    S_SCAN,
    S_TIMER,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SEQ_W-1:0] seq_num;
    logic             header_bad;
  } in_word_t;

  typedef struct packed {
    logic             release_valid;
    logic [SEQ_W-1:0] release_sn;
    logic [1:0]       status;
    logic             timer_start;
    logic             timer_stop;
    logic [SEQ_W-1:0] recv_state;
    logic [SEQ_W-1:0] high_state;
    logic             last;
  } out_word_t;

  // Offset of a sequence number above the window base (high - WINDOW).
  function automatic sn_t win_off(sn_t sn, sn_t high);
    return sn - high + sn_t'(WINDOW);
  endfunction

endpackage

`default_nettype wire

// ===== design/um_reordering_window.sv =====
// Receive reordering window for unacknowledged-mode PDUs, built around an occupancy memory.
// An item is taken when start is high and busy is low; busy stays high until its last result
// word has been launched. A bad-header or unused-code item goes straight to its result word
// and a discarded PDU is evaluated first. A stored PDU or a timer expiry can also run the
// next-missing search, a scan of a released range and the read-out of each released word,
// which read the occupancy map and the release buffer, each with one read port, one entry at
// a time. A re-establish also wipes the map, one entry a cycle. After reset the same wipe
// runs before the first item is taken. Result words come out on out_valid for one cycle
// each, in order, and cannot be held off.
`default_nettype none

module um_reordering_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  urw_pkg::in_word_t  in_data,
  output logic               out_valid,
  output urw_pkg::out_word_t out_data
);

  urw_pkg::state_t    state_r, state_nxt;
  urw_pkg::state_t    ret_r, ret_nxt;
  urw_pkg::sn_t       sn_r, sn_nxt;
  urw_pkg::sn_t       recv_r, recv_nxt;
  urw_pkg::sn_t       high_r, high_nxt;
  urw_pkg::sn_t       trig_r, trig_nxt;
  logic               run_r, run_nxt;
  urw_pkg::sn_t       ptr_r, ptr_nxt;
  urw_pkg::sn_t       mark_r, mark_nxt;
  urw_pkg::cnt_t      cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  urw_pkg::sn_t       pend_addr_r, pend_addr_nxt;
  urw_pkg::cnt_t      nrel_r, nrel_nxt;
  urw_pkg::cnt_t      eidx_r, eidx_nxt;
  logic               ep_r, ep_nxt;
  logic               ep_last_r, ep_last_nxt;
  urw_pkg::status_t   status_r, status_nxt;
  logic               tstart_r, tstart_nxt;
  logic               tstop_r, tstop_nxt;
  logic               out_valid_r, out_valid_nxt;
  urw_pkg::out_word_t out_data_r, out_data_nxt;

  // Occupancy map and release buffer.
  logic               map_mem [urw_pkg::SN_MOD];
  urw_pkg::sn_t       rel_mem [urw_pkg::SN_MOD];
  logic               map_q_r;
  urw_pkg::sn_t       rel_q_r;
  logic               map_we, map_wd, map_re;
  urw_pkg::sn_t       map_wa, map_ra;
  logic               rel_we, rel_re;

  // Offsets above the window base.
  urw_pkg::sn_t off_recv, off_high, off_sn, off_trig, off_ptr, off_mark;
  assign off_recv = urw_pkg::win_off(recv_r, high_r);
  assign off_high = urw_pkg::win_off(high_r, high_r);
  assign off_sn   = urw_pkg::win_off(sn_r, high_r);
  assign off_trig = urw_pkg::win_off(trig_r, high_r);
  assign off_ptr  = urw_pkg::win_off(ptr_r, high_r);
  assign off_mark = urw_pkg::win_off(mark_r, high_r);

  // PDU evaluation.
  logic         disc, grow, jump;
  urw_pkg::sn_t high_new, base_new;
  assign disc = ((off_recv < off_sn) && (off_sn < off_high) && map_q_r) || (off_sn < off_recv);
  assign grow = !(off_sn < off_high);
  assign high_new = sn_r + urw_pkg::sn_t'(1);
  assign base_new = high_new - urw_pkg::sn_t'(urw_pkg::WINDOW);
  assign jump = urw_pkg::win_off(recv_r, high_new) >= urw_pkg::sn_t'(urw_pkg::WINDOW);

  // Next-missing search; reads are issued ahead while earlier data returns.
  logic         f_hit, f_issue, f_done;
  urw_pkg::sn_t f_recv, f_cnt;
  assign f_hit   = pend_r && !map_q_r;
  assign f_issue = off_recv < off_ptr;
  assign f_done  = f_hit || (!f_issue && !pend_r);
  assign f_recv  = f_hit ? pend_addr_r : recv_r;
  assign f_cnt   = urw_pkg::win_off(f_recv, high_r) - off_mark;

  logic s_done, c_done;
  assign s_done = (cnt_r == '0) && !pend_r;
  assign c_done = (cnt_r == '0);

  // Reordering timer decisions.
  logic stop_c, run_mid, start_c;
  assign stop_c  = run_r && ((off_trig <= off_recv) || (off_trig > off_high));
  assign run_mid = run_r && !stop_c;
  assign start_c = !run_mid && (off_high > off_recv);

  // Releases below the window top on re-establish.
  urw_pkg::sn_t r_cnt;
  assign r_cnt = (off_recv < off_high) ? (off_high - off_recv) : '0;

  logic e_issue, e_done;
  assign e_issue = eidx_r < nrel_r;
  assign e_done  = (nrel_r == '0) || (ep_r && ep_last_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      urw_pkg::S_CLEAR: begin
        if (c_done) state_nxt = ret_r;
      end
      urw_pkg::S_IDLE: begin
        if (start) begin
          unique case (in_data.operation)
            urw_pkg::OP_PDU:    state_nxt = in_data.header_bad ? urw_pkg::S_EMIT
                                                               : urw_pkg::S_PDU_EVAL;
            urw_pkg::OP_EXPIRE: state_nxt = urw_pkg::S_FIND;
            urw_pkg::OP_REEST:  state_nxt = urw_pkg::S_SCAN;
            default:            state_nxt = urw_pkg::S_EMIT;
          endcase
        end
      end
      urw_pkg::S_PDU_EVAL: begin
        if (disc) state_nxt = urw_pkg::S_EMIT;
        else if (grow && jump) state_nxt = urw_pkg::S_SCAN;
        else state_nxt = urw_pkg::S_RUN_CHECK;
      end
      urw_pkg::S_RUN_CHECK: state_nxt = urw_pkg::S_RUN_EVAL;
      urw_pkg::S_RUN_EVAL:  state_nxt = map_q_r ? urw_pkg::S_FIND : urw_pkg::S_TIMER;
      urw_pkg::S_FIND: begin
        if (f_done) state_nxt = urw_pkg::S_SCAN;
      end
      urw_pkg::S_SCAN: begin
        if (s_done) state_nxt = ret_r;
      end
      urw_pkg::S_TIMER: state_nxt = urw_pkg::S_EMIT;
      urw_pkg::S_EMIT: begin
        if (e_done) state_nxt = urw_pkg::S_IDLE;
      end
      default: state_nxt = urw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt       = ret_r;
    sn_nxt        = sn_r;
    recv_nxt      = recv_r;
    high_nxt      = high_r;
    trig_nxt      = trig_r;
    run_nxt       = run_r;
    ptr_nxt       = ptr_r;
    mark_nxt      = mark_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    nrel_nxt      = nrel_r;
    eidx_nxt      = eidx_r;
    ep_nxt        = 1'b0;
    ep_last_nxt   = ep_last_r;
    status_nxt    = status_r;
    tstart_nxt    = tstart_r;
    tstop_nxt     = tstop_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    map_we        = 1'b0;
    map_wd        = 1'b0;
    map_wa        = ptr_r;
    map_re        = 1'b0;
    map_ra        = ptr_r;
    rel_we        = 1'b0;
    rel_re        = 1'b0;

    unique case (state_r)
      urw_pkg::S_CLEAR: begin
        if (!c_done) begin
          map_we  = 1'b1;
          map_wa  = ptr_r;
          ptr_nxt = ptr_r + urw_pkg::sn_t'(1);
          cnt_nxt = cnt_r - urw_pkg::cnt_t'(1);
        end
      end
      urw_pkg::S_IDLE: begin
        if (start) begin
          sn_nxt     = urw_pkg::sn_t'(in_data.seq_num);
          nrel_nxt   = '0;
          eidx_nxt   = '0;
          tstart_nxt = 1'b0;
          tstop_nxt  = 1'b0;
          status_nxt = urw_pkg::STAT_CTRL;
          map_re     = 1'b1;
          map_ra     = urw_pkg::sn_t'(in_data.seq_num);
          unique case (in_data.operation)
            urw_pkg::OP_PDU: begin
              status_nxt = in_data.header_bad ? urw_pkg::STAT_HDR_ERR : urw_pkg::STAT_STORED;
            end
            urw_pkg::OP_EXPIRE: begin
              run_nxt  = 1'b0;
              mark_nxt = recv_r;
              ptr_nxt  = trig_r;
              ret_nxt  = urw_pkg::S_TIMER;
            end
            urw_pkg::OP_REEST: begin
              tstop_nxt = run_r;
              run_nxt   = 1'b0;
              ptr_nxt   = recv_r;
              cnt_nxt   = urw_pkg::cnt_t'(r_cnt);
              ret_nxt   = urw_pkg::S_CLEAR;
            end
            default: begin
              status_nxt = urw_pkg::STAT_CTRL;
            end
          endcase
        end
      end
      urw_pkg::S_PDU_EVAL: begin
        if (disc) begin
          status_nxt = urw_pkg::STAT_DUP;
        end else begin
          map_we = 1'b1;
          map_wa = sn_r;
          map_wd = 1'b1;
          if (grow) begin
            high_nxt = high_new;
            // The receive point fell below the new base: flush the skipped range.
            if (jump) begin
              recv_nxt = base_new;
              ptr_nxt  = recv_r;
              cnt_nxt  = urw_pkg::cnt_t'(urw_pkg::sn_t'(base_new - recv_r));
              ret_nxt  = urw_pkg::S_RUN_CHECK;
            end
          end
        end
      end
      urw_pkg::S_RUN_CHECK: begin
        map_re = 1'b1;
        map_ra = recv_r;
      end
      urw_pkg::S_RUN_EVAL: begin
        if (map_q_r) begin
          mark_nxt = recv_r;
          ptr_nxt  = recv_r + urw_pkg::sn_t'(1);
          ret_nxt  = urw_pkg::S_TIMER;
        end
      end
      urw_pkg::S_FIND: begin
        if (f_hit) begin
          recv_nxt = pend_addr_r;
        end else if (f_issue) begin
          map_re        = 1'b1;
          map_ra        = ptr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + urw_pkg::sn_t'(1);
        end
        // The stored entries from the mark up to the new receive point are released next.
        if (f_done) begin
          ptr_nxt = mark_r;
          cnt_nxt = urw_pkg::cnt_t'(f_cnt);
        end
      end
      urw_pkg::S_SCAN: begin
        if (pend_r && map_q_r) begin
          map_we   = 1'b1;
          map_wa   = pend_addr_r;
          rel_we   = 1'b1;
          nrel_nxt = nrel_r + urw_pkg::cnt_t'(1);
        end
        if (cnt_r != '0) begin
          map_re        = 1'b1;
          map_ra        = ptr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + urw_pkg::sn_t'(1);
          cnt_nxt       = cnt_r - urw_pkg::cnt_t'(1);
        end
        if (s_done && (ret_r == urw_pkg::S_CLEAR)) begin
          recv_nxt = '0;
          high_nxt = '0;
          trig_nxt = '0;
          ptr_nxt  = '0;
          cnt_nxt  = urw_pkg::cnt_t'(urw_pkg::SN_MOD);
          ret_nxt  = urw_pkg::S_EMIT;
        end
      end
      urw_pkg::S_TIMER: begin
        tstop_nxt  = stop_c;
        tstart_nxt = start_c;
        run_nxt    = run_mid || start_c;
        if (start_c) trig_nxt = high_r;
      end
      urw_pkg::S_EMIT: begin
        out_data_nxt.status     = status_r;
        out_data_nxt.recv_state = recv_r[urw_pkg::SEQ_W-1:0];
        out_data_nxt.high_state = high_r[urw_pkg::SEQ_W-1:0];
        if (nrel_r == '0) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.release_valid = 1'b0;
          out_data_nxt.release_sn    = '0;
          out_data_nxt.timer_start   = tstart_r;
          out_data_nxt.timer_stop    = tstop_r;
          out_data_nxt.last          = 1'b1;
        end else begin
          if (e_issue) begin
            rel_re      = 1'b1;
            ep_nxt      = 1'b1;
            ep_last_nxt = (eidx_r + urw_pkg::cnt_t'(1)) == nrel_r;
            eidx_nxt    = eidx_r + urw_pkg::cnt_t'(1);
          end
          if (ep_r) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.release_valid = 1'b1;
            out_data_nxt.release_sn    = rel_q_r[urw_pkg::SEQ_W-1:0];
            out_data_nxt.timer_start   = tstart_r && ep_last_r;
            out_data_nxt.timer_stop    = tstop_r && ep_last_r;
            out_data_nxt.last          = ep_last_r;
          end
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_q_r <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (rel_we) rel_mem[nrel_r[urw_pkg::SN_BITS-1:0]] <= pend_addr_r;
    if (rel_re) rel_q_r <= rel_mem[eidx_r[urw_pkg::SN_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urw_pkg::S_CLEAR;
      ret_r       <= urw_pkg::S_IDLE;
      recv_r      <= '0;
      high_r      <= '0;
      trig_r      <= '0;
      run_r       <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= urw_pkg::cnt_t'(urw_pkg::SN_MOD);
      pend_r      <= 1'b0;
      nrel_r      <= '0;
      eidx_r      <= '0;
      ep_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      recv_r      <= recv_nxt;
      high_r      <= high_nxt;
      trig_r      <= trig_nxt;
      run_r       <= run_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      nrel_r      <= nrel_nxt;
      eidx_r      <= eidx_nxt;
      ep_r        <= ep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sn_r        <= sn_nxt;
    mark_r      <= mark_nxt;
    pend_addr_r <= pend_addr_nxt;
    ep_last_r   <= ep_last_nxt;
    status_r    <= status_nxt;
    tstart_r    <= tstart_nxt;
    tstop_r     <= tstop_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != urw_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The scan writes back behind its reads, so a write never meets a read of the same entry.
  a_map_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (map_we && map_re) |-> (map_wa != map_ra))
    else $error("occupancy map read and write hit the same entry");

  a_release_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nrel_r <= urw_pkg::cnt_t'(urw_pkg::SN_MOD))
    else $error("release buffer overflow");

  a_empty_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.release_valid) |-> (out_data.last && (out_data.release_sn == '0)))
    else $error("word without a release is not the only word of its item");

  a_timer_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (!out_data.timer_start && !out_data.timer_stop))
    else $error("timer command on a word other than the last");

endmodule

`default_nettype wire
